>>> rtl/core/rmpf_pkg.sv
package rmpf_pkg;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	typedef struct packed {
		logic del;
		logic ins;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEL,
		ST_INS,
		ST_SEL
	} state_t;

endpackage

>>> rtl/core/rmpf_ram.sv
module rmpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 30
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a read and a write to one address return the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/rmpf_cell.sv
module rmpf_cell #(
	parameter int IDX_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmpf_pkg::cell_ctl_t ctl,
	input  rmpf_pkg::point_t    new_pt,
	input  logic [IDX_W-1:0]    new_slot,
	input  logic signed [15:0]  del_y,
	input  logic [IDX_W-1:0]    del_slot,
	input  logic                lo_vld,
	input  logic                lo_gt,
	input  rmpf_pkg::point_t    lo_pt,
	input  logic [IDX_W-1:0]    lo_slot,
	input  logic                hi_vld,
	input  rmpf_pkg::point_t    hi_pt,
	input  logic [IDX_W-1:0]    hi_slot,
	output logic                vld,
	output rmpf_pkg::point_t    pt,
	output logic [IDX_W-1:0]    slot,
	output logic                gt
);

	logic             vld_q;
	rmpf_pkg::point_t pt_q;
	logic [IDX_W-1:0] slot_q;
	logic             ge_del;

	// key is (y, slot); an empty cell counts as above every key
	assign gt = !vld_q || ($signed(pt_q.y) > $signed(new_pt.y)) ||
		(($signed(pt_q.y) == $signed(new_pt.y)) && (slot_q > new_slot));

	assign ge_del = vld_q && (($signed(pt_q.y) > del_y) ||
		(($signed(pt_q.y) == del_y) && (slot_q >= del_slot)));

	// an insert into an empty cell whose lower neighbour is also empty leaves it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.del && ge_del) begin
			vld_q <= hi_vld;
		end else if (ctl.ins && gt) begin
			vld_q <= lo_gt ? lo_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.del && ge_del) begin
			pt_q   <= hi_pt;
			slot_q <= hi_slot;
		end else if (ctl.ins && gt) begin
			if (lo_gt) begin
				pt_q   <= lo_pt;
				slot_q <= lo_slot;
			end else begin
				pt_q   <= new_pt;
				slot_q <= new_slot;
			end
		end
	end

	assign vld  = vld_q;
	assign pt   = pt_q;
	assign slot = slot_q;

endmodule

>>> rtl/core/running_median_point_filter.sv
// channel | signals                      | direction | accepted when
// in      | in_valid, in_ready, in_x/y/z | input     | in_valid && in_ready
// out     | out_valid, out_ready,         | output    | out_valid && out_ready
//         | med_x/y/z                    |           |
//
// One transaction at a time: while the window fills, each point is accepted,
// inserted and selected; once it is full, a delete pass down the sorted cell
// chain comes between accept and insert. The chain shifts one cell per pass,
// so the cost does not grow with WINDOW. The next point is taken while a
// result waits in the output register; a stalled output holds the select
// step until it drains. arst_n empties the chain and restarts the fill.
module running_median_point_filter #(
	parameter int WINDOW = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_x,
	input  logic signed [15:0] in_y,
	input  logic signed [15:0] in_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] med_x,
	output logic signed [15:0] med_y,
	output logic signed [15:0] med_z
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0] FULL_RANK = IDX_W'(WINDOW / 2);

	rmpf_pkg::state_t    state_q, state_d;
	rmpf_pkg::cell_ctl_t ctl;
	logic                accept;
	logic                load;

	logic [IDX_W-1:0] ws_q;
	logic             filling_q;
	rmpf_pkg::point_t new_pt_q;
	logic [IDX_W-1:0] new_slot_q;
	logic [IDX_W-1:0] rank_q;
	logic [15:0]      del_y_raw;
	rmpf_pkg::point_t out_pt_q;
	logic             out_valid_q;

	logic [WINDOW-1:0] cell_vld;
	logic [WINDOW-1:0] cell_gt;
	rmpf_pkg::point_t  cell_pt [WINDOW];
	logic [IDX_W-1:0]  cell_slot [WINDOW];

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmpf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = filling_q ? rmpf_pkg::ST_INS : rmpf_pkg::ST_DEL;
				end
			end
			rmpf_pkg::ST_DEL: state_d = rmpf_pkg::ST_INS;
			rmpf_pkg::ST_INS: state_d = rmpf_pkg::ST_SEL;
			rmpf_pkg::ST_SEL: begin
				if (!out_valid_q || out_ready) begin
					state_d = rmpf_pkg::ST_IDLE;
				end
			end
			default: state_d = rmpf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == rmpf_pkg::ST_IDLE);
		ctl.del  = (state_q == rmpf_pkg::ST_DEL);
		ctl.ins  = (state_q == rmpf_pkg::ST_INS);
		load     = (state_q == rmpf_pkg::ST_SEL) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmpf_pkg::ST_IDLE;
			ws_q        <= '0;
			filling_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (ws_q == LAST_SLOT) begin
					ws_q      <= '0;
					filling_q <= 1'b0;
				end else begin
					ws_q <= ws_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_pt_q   <= '{x: in_x, y: in_y, z: in_z};
			new_slot_q <= ws_q;
			rank_q     <= filling_q ? (ws_q >> 1) : FULL_RANK;
		end
		if (load) begin
			out_pt_q <= cell_pt[rank_q];
		end
	end

	// y of each ring slot, so the point leaving the window can be found by key
	rmpf_ram #(
		.WIDTH(16),
		.DEPTH(WINDOW)
	) u_ring_y (
		.clk  (clk),
		.we   (accept),
		.waddr(ws_q),
		.wdata(in_y),
		.raddr(ws_q),
		.rdata(del_y_raw)
	);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic             lo_vld, lo_gt, hi_vld;
		rmpf_pkg::point_t lo_pt, hi_pt;
		logic [IDX_W-1:0] lo_slot, hi_slot;

		if (i == 0) begin : g_lo_end
			assign lo_vld  = 1'b0;
			assign lo_gt   = 1'b0;
			assign lo_pt   = '0;
			assign lo_slot = '0;
		end else begin : g_lo
			assign lo_vld  = cell_vld[i-1];
			assign lo_gt   = cell_gt[i-1];
			assign lo_pt   = cell_pt[i-1];
			assign lo_slot = cell_slot[i-1];
		end

		if (i == WINDOW - 1) begin : g_hi_end
			assign hi_vld  = 1'b0;
			assign hi_pt   = '0;
			assign hi_slot = '0;
		end else begin : g_hi
			assign hi_vld  = cell_vld[i+1];
			assign hi_pt   = cell_pt[i+1];
			assign hi_slot = cell_slot[i+1];
		end

		rmpf_cell #(
			.IDX_W(IDX_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_pt  (new_pt_q),
			.new_slot(new_slot_q),
			.del_y   ($signed(del_y_raw)),
			.del_slot(new_slot_q),
			.lo_vld  (lo_vld),
			.lo_gt   (lo_gt),
			.lo_pt   (lo_pt),
			.lo_slot (lo_slot),
			.hi_vld  (hi_vld),
			.hi_pt   (hi_pt),
			.hi_slot (hi_slot),
			.vld     (cell_vld[i]),
			.pt      (cell_pt[i]),
			.slot    (cell_slot[i]),
			.gt      (cell_gt[i])
		);
	end

	assign out_valid = out_valid_q;
	assign med_x     = out_pt_q.x;
	assign med_y     = out_pt_q.y;
	assign med_z     = out_pt_q.z;

	a_full_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmpf_pkg::ST_IDLE) && !filling_q |-> (&cell_vld))
		else $error("chain not full once window has filled");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmpf_pkg::ST_IDLE) && filling_q |->
		($countones(cell_vld) == int'(ws_q)))
		else $error("occupied cells disagree with fill position");

	a_one_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmpf_pkg::ST_DEL) |=> ($countones(cell_vld) == WINDOW - 1))
		else $error("delete pass did not remove exactly one point");

endmodule
